// ----- hdl/depth_sorted_draw_list_macros.svh -----
// Assertion macros for the depth-sorted draw list.
// Used by the top level; expects clk and arst_n in the scope of use.
`ifndef DEPTH_SORTED_DRAW_LIST_MACROS_SVH
`define DEPTH_SORTED_DRAW_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSDL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSDL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/dsdl_pkg.sv -----
// Package for the depth-sorted draw list: sizes, operation codes, item types.
// Holds the saturating add used on render; depends on nothing.
`default_nettype none

package dsdl_pkg;

	localparam int CAPACITY   = 64;
	localparam int COORD_BITS = 16;
	localparam int ID_W       = 6;
	localparam int OPA_W      = 7;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;

	typedef struct packed {
		logic [1:0]                   operation;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic [OPA_W-1:0]             opacity;
		logic signed [COORD_BITS-1:0] offset_x;
		logic signed [COORD_BITS-1:0] offset_y;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]              entry_id;
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic [OPA_W-1:0]             out_opacity;
		logic                         is_render;
		logic                         last;
		logic                         rejected;
	} out_item_t;

	// One stored entry as it sits in a cell.
	typedef struct packed {
		logic [ID_W-1:0]              id;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [OPA_W-1:0]             opa;
	} entry_t;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic clr;
		logic ins;
		logic rot;
	} cell_ctrl_t;

	// Signed add clamped to the coordinate range.
	function automatic logic signed [COORD_BITS-1:0] sat_add(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] sum;
		logic signed [COORD_BITS-1:0] res;
		sum = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
		if (sum[COORD_BITS] != sum[COORD_BITS-1]) begin
			res = sum[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
			                      : {1'b0, {(COORD_BITS-1){1'b1}}};
		end else begin
			res = sum[COORD_BITS-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/dsdl_cell.sv -----
// One cell of the sorted row: holds a single entry and its valid bit.
// Depends on dsdl_pkg for the entry and control types.
`default_nettype none

module dsdl_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  dsdl_pkg::cell_ctrl_t ctrl,
	input  dsdl_pkg::entry_t     new_entry,
	input  dsdl_pkg::entry_t     left_entry,
	input  wire                  left_valid,
	input  wire                  left_greater,
	input  dsdl_pkg::entry_t     right_entry,
	input  wire                  right_valid,
	input  dsdl_pkg::entry_t     wrap_entry,
	output dsdl_pkg::entry_t     entry,
	output logic                 valid,
	output logic                 greater
);
	import dsdl_pkg::*;

	entry_t entry_q;
	logic   valid_q;
	logic   take_ins;

	// The row is sorted, so the cells holding a larger y form a tail; the
	// first of them, or the first empty cell, takes the new entry.
	assign greater  = valid_q && (new_entry.y < entry_q.y);
	assign take_ins = ctrl.ins && (greater || (!valid_q && left_valid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (take_ins) begin
			valid_q <= 1'b1;
		end
	end

	// Insert shifts the tail right; render rotates the filled part left,
	// the last filled cell taking the head so the order comes back.
	always_ff @(posedge clk) begin
		if (take_ins) begin
			entry_q <= left_greater ? left_entry : new_entry;
		end else if (ctrl.rot && valid_q) begin
			entry_q <= right_valid ? right_entry : wrap_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// ----- hdl/dsdl_chain.sv -----
// Row of CAPACITY cells wired to their neighbours; the head is cell 0.
// Depends on dsdl_pkg and dsdl_cell.
`default_nettype none

module dsdl_chain (
	input  wire                  clk,
	input  wire                  arst_n,
	input  dsdl_pkg::cell_ctrl_t ctrl,
	input  dsdl_pkg::entry_t     new_entry,
	output dsdl_pkg::entry_t     head
);
	import dsdl_pkg::*;

	entry_t entries [CAPACITY];
	logic   valids  [CAPACITY];
	logic   greats  [CAPACITY];

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			entry_t left_e;
			logic   left_v;
			logic   left_g;
			entry_t right_e;
			logic   right_v;

			// The head sees an always-filled, never-greater left side.
			if (i == 0) begin : g_first
				assign left_e = new_entry;
				assign left_v = 1'b1;
				assign left_g = 1'b0;
			end else begin : g_mid_l
				assign left_e = entries[i-1];
				assign left_v = valids[i-1];
				assign left_g = greats[i-1];
			end

			// The final cell has nothing to its right.
			if (i == CAPACITY - 1) begin : g_final
				assign right_e = entries[0];
				assign right_v = 1'b0;
			end else begin : g_mid_r
				assign right_e = entries[i+1];
				assign right_v = valids[i+1];
			end

			dsdl_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.new_entry    (new_entry),
				.left_entry   (left_e),
				.left_valid   (left_v),
				.left_greater (left_g),
				.right_entry  (right_e),
				.right_valid  (right_v),
				.wrap_entry   (entries[0]),
				.entry        (entries[i]),
				.valid        (valids[i]),
				.greater      (greats[i])
			);
		end
	endgenerate

	assign head = entries[0];

endmodule

`default_nettype wire

// ----- hdl/depth_sorted_draw_list.sv -----
// Top level of the depth-sorted draw list: command decode, render sequencing
// and the result register. Depends on dsdl_pkg, dsdl_chain and the macro header.
//
// Usage. A command transfers at a rising edge with start high and busy low.
// Clear empties the list at once and gives no result. Add stores the entry in
// a row of cells, every cell comparing its y with the new one in parallel,
// and the insert completes in the same cycle; one result (the id, or rejected
// when the list is full) appears on the next cycle and busy stays low, so a
// command may follow in every cycle. Render takes a snapshot of the count and
// then streams the n stored entries one per cycle through the result register,
// offsets added and saturated, last marking the final one; busy stays high while
// the row rotates through its filled cells to present each entry at its head.
// An empty list renders nothing. Each result is held on result for one cycle
// with strobe high; the receiver cannot stall the block. Reset empties the
// list and clears any render in progress; no clearing pass is needed.
`default_nettype none
`include "depth_sorted_draw_list_macros.svh"

module depth_sorted_draw_list (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  dsdl_pkg::in_item_t  request,
	output logic                strobe,
	output dsdl_pkg::out_item_t result
);
	import dsdl_pkg::*;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      remain_q;
	logic [COORD_BITS-1:0] off_x_q;
	logic [COORD_BITS-1:0] off_y_q;
	logic                  strobe_q;
	out_item_t             result_q;

	logic       accept;
	logic       full;
	logic       do_clear;
	logic       do_add;
	logic       do_render;
	cell_ctrl_t ctrl;
	entry_t     new_entry;
	entry_t     head;

	// Command decode.
	assign busy   = (remain_q != '0);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		do_clear  = 1'b0;
		do_add    = 1'b0;
		do_render = 1'b0;
		unique case (request.operation)
			OP_CLEAR:  do_clear  = accept;
			OP_ADD:    do_add    = accept;
			OP_RENDER: do_render = accept;
			default:   ;
		endcase
	end

	assign ctrl.clr = do_clear;
	assign ctrl.ins = do_add && !full;
	assign ctrl.rot = busy;

	assign new_entry.id  = count_q[ID_W-1:0];
	assign new_entry.x   = request.pos_x;
	assign new_entry.y   = request.pos_y;
	assign new_entry.opa = request.opacity;

	dsdl_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.new_entry (new_entry),
		.head      (head)
	);

	// Fill count and render sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			remain_q <= '0;
		end else begin
			if (do_clear) begin
				count_q <= '0;
			end else if (ctrl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (do_render) begin
				remain_q <= count_q;
			end else if (busy) begin
				remain_q <= remain_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_render) begin
			off_x_q <= request.offset_x;
			off_y_q <= request.offset_y;
		end
	end

	// Result register: add acknowledgement or the entry at the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= do_add || busy;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			result_q.entry_id    <= head.id;
			result_q.out_x       <= sat_add(head.x, off_x_q);
			result_q.out_y       <= sat_add(head.y, off_y_q);
			result_q.out_opacity <= head.opa;
			result_q.is_render   <= 1'b1;
			result_q.last        <= (remain_q == CNT_W'(1));
			result_q.rejected    <= 1'b0;
		end else if (do_add) begin
			result_q.entry_id    <= full ? '0 : count_q[ID_W-1:0];
			result_q.out_x       <= '0;
			result_q.out_y       <= '0;
			result_q.out_opacity <= '0;
			result_q.is_render   <= 1'b0;
			result_q.last        <= 1'b1;
			result_q.rejected    <= full;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// Checks on sequencing and the fill count.
	`DSDL_ASSERT_NXT(a_render_streams, busy, strobe && result.is_render, "render result missing")
	`DSDL_ASSERT_IMP(a_last_ends_run, strobe && result.is_render && result.last, !busy, "last before end of run")
	`DSDL_ASSERT_NXT(a_add_counts, ctrl.ins, count_q == $past(count_q) + CNT_W'(1), "count did not advance")
	`DSDL_ASSERT_NXT(a_clear_empties, do_clear, count_q == '0 && !busy, "clear left entries")

endmodule

`default_nettype wire

// ----- verif/depth_sorted_draw_list_checker.sv -----
`timescale 1ns / 100ps
// Checker for the depth-sorted draw list: watches command and result transfers,
// keeps its own copy of the sorted list and compares every result. Uses dsdl_pkg.

module depth_sorted_draw_list_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire                 busy,
	input  dsdl_pkg::in_item_t  request,
	input  wire                 strobe,
	input  dsdl_pkg::out_item_t result,
	output int                  mismatches,
	output int                  pending
);
	import dsdl_pkg::*;

	// Shadow copy of the stored entries and their order by y.
	logic [ID_W-1:0]              draw_order [CAPACITY];
	logic signed [COORD_BITS-1:0] stored_x   [CAPACITY];
	logic signed [COORD_BITS-1:0] stored_y   [CAPACITY];
	logic [OPA_W-1:0]             stored_opa [CAPACITY];
	int unsigned                  stored_count = 0;

	out_item_t awaited_results[$];
	int        fail_count = 0;

	// Signed sum clamped to the coordinate range.
	function automatic logic signed [COORD_BITS-1:0] clamp_sum(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		longint s;
		longint hi;
		longint lo;
		hi = (longint'(1) << (COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		s = longint'(a) + longint'(b);
		if (s > hi) begin
			s = hi;
		end else if (s < lo) begin
			s = lo;
		end
		return s[COORD_BITS-1:0];
	endfunction

	// Applies one accepted command to the shadow list and queues its results.
	task automatic predict_command(input in_item_t cmd);
		out_item_t      r;
		int unsigned    slot;
		int             i;
		logic [ID_W-1:0] id;
		case (cmd.operation)
			OP_CLEAR: begin
				stored_count = 0;
			end
			OP_ADD: begin
				r = '0;
				r.last = 1'b1;
				if (stored_count >= CAPACITY) begin
					r.rejected = 1'b1;
				end else begin
					stored_x[stored_count]   = cmd.pos_x;
					stored_y[stored_count]   = cmd.pos_y;
					stored_opa[stored_count] = cmd.opacity;
					// The new id goes before the first entry with a strictly greater y.
					slot = stored_count;
					for (i = 0; i < stored_count; i++) begin
						if (cmd.pos_y < stored_y[draw_order[i]]) begin
							slot = i;
							break;
						end
					end
					for (i = stored_count; i > slot; i--) begin
						draw_order[i] = draw_order[i-1];
					end
					draw_order[slot] = ID_W'(stored_count);
					r.entry_id = ID_W'(stored_count);
					stored_count++;
				end
				awaited_results.push_back(r);
			end
			OP_RENDER: begin
				for (i = 0; i < stored_count; i++) begin
					id = draw_order[i];
					r = '0;
					r.entry_id    = id;
					r.out_x       = clamp_sum(stored_x[id], cmd.offset_x);
					r.out_y       = clamp_sum(stored_y[id], cmd.offset_y);
					r.out_opacity = stored_opa[id];
					r.is_render   = 1'b1;
					r.last        = (i == stored_count - 1);
					awaited_results.push_back(r);
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic bit field_matches(
		input string       name,
		input logic [31:0] want,
		input logic [31:0] got
	);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Results are checked before the command of the same edge is predicted;
	// a command never produces a result at its own transfer edge.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		bit        ok;
		if (!arst_n) begin
			stored_count = 0;
			awaited_results.delete();
			pending    <= 0;
			mismatches <= fail_count;
		end else begin
			if (strobe) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result expected none, got %p", $time, result);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					ok = 1'b1;
					ok &= field_matches("entry_id", 32'(want.entry_id), 32'(result.entry_id));
					ok &= field_matches("out_x", 32'(unsigned'(want.out_x)),
						32'(unsigned'(result.out_x)));
					ok &= field_matches("out_y", 32'(unsigned'(want.out_y)),
						32'(unsigned'(result.out_y)));
					ok &= field_matches("out_opacity", 32'(want.out_opacity),
						32'(result.out_opacity));
					ok &= field_matches("is_render", 32'(want.is_render), 32'(result.is_render));
					ok &= field_matches("last", 32'(want.last), 32'(result.last));
					ok &= field_matches("rejected", 32'(want.rejected), 32'(result.rejected));
					if (!ok) begin
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				predict_command(request);
			end
			pending    <= awaited_results.size();
			mismatches <= fail_count;
		end
	end

endmodule

// ----- verif/depth_sorted_draw_list_tb.sv -----
`timescale 1ns / 100ps
// Top of the draw list testbench: clock, reset and command stimulus.
// Depends on dsdl_pkg, the block and depth_sorted_draw_list_checker.

module depth_sorted_draw_list_tb;
	import dsdl_pkg::*;

	// Operation code the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  request;
	logic      strobe;
	out_item_t result;
	int        mismatches;
	int        pending;

	always #2 clk = ~clk;

	depth_sorted_draw_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.strobe (strobe),
		.result (result)
	);

	depth_sorted_draw_list_checker draw_list_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.strobe    (strobe),
		.result    (result),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// Coordinates lean towards the extremes and a few small values, so ties occur.
	function automatic logic signed [COORD_BITS-1:0] pick_coord();
		logic signed [COORD_BITS-1:0] v;
		case ($urandom_range(0, 7))
			0:       v = {1'b1, {(COORD_BITS-1){1'b0}}};
			1:       v = {1'b0, {(COORD_BITS-1){1'b1}}};
			2, 3: begin
				v = COORD_BITS'(int'($urandom_range(0, 6)) - 3);
			end
			default: v = COORD_BITS'($urandom);
		endcase
		return v;
	endfunction

	function automatic in_item_t make_item(
		input logic [1:0]                   op,
		input logic signed [COORD_BITS-1:0] x,
		input logic signed [COORD_BITS-1:0] y,
		input logic [OPA_W-1:0]             opa,
		input logic signed [COORD_BITS-1:0] ox,
		input logic signed [COORD_BITS-1:0] oy
	);
		in_item_t it;
		it.operation = op;
		it.pos_x     = x;
		it.pos_y     = y;
		it.opacity   = opa;
		it.offset_x  = ox;
		it.offset_y  = oy;
		return it;
	endfunction

	function automatic in_item_t random_item(input logic [1:0] op);
		logic [OPA_W-1:0] opa;
		opa = $urandom_range(0, 1) ? OPA_W'($urandom_range(0, 100))
		                           : OPA_W'($urandom_range(0, 127));
		return make_item(op, pick_coord(), pick_coord(), opa, pick_coord(), pick_coord());
	endfunction

	// Idles each cycle with the given chance, then holds one command until it transfers.
	task automatic issue(input in_item_t it, input int gap_pct);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= it;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// Stops sending until every outstanding result has been seen.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Random scenes: an optional clear, a run of adds with some noise, then renders.
	task automatic run_phase(input int gap_pct, input int budget, input bit with_fill);
		int sent;
		int adds;
		int i;
		sent = 0;
		if (with_fill) begin
			// Fill the list completely and push two more adds into the full list.
			issue(random_item(OP_CLEAR), gap_pct);
			for (i = 0; i < CAPACITY + 2; i++) begin
				issue(random_item(OP_ADD), gap_pct);
			end
			issue(random_item(OP_RENDER), gap_pct);
			issue(random_item(OP_CLEAR), gap_pct);
			sent += CAPACITY + 5;
		end
		while (sent < budget) begin
			if ($urandom_range(0, 9) < 6) begin
				issue(random_item(OP_CLEAR), gap_pct);
				sent++;
			end
			adds = $urandom_range(0, 10);
			for (i = 0; i < adds; i++) begin
				case ($urandom_range(0, 9))
					0:       issue(random_item(OP_UNUSED), gap_pct);
					1: begin
						issue(random_item(OP_RENDER), gap_pct);
						sent++;
					end
					default: begin
						issue(random_item(OP_ADD), gap_pct);
						sent++;
					end
				endcase
			end
			repeat ($urandom_range(1, 2)) begin
				issue(random_item(OP_RENDER), gap_pct);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n  <= 1'b0;
		start   <= 1'b0;
		request <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty render, ignored code, extremes, ties, saturation both ways.
		issue(make_item(OP_RENDER, 16'sd5, 16'sd5, 7'd5, 16'sd1, 16'sd1), 0);
		issue(make_item(OP_UNUSED, 16'sd1, 16'sd2, 7'd3, 16'sd4, 16'sd5), 0);
		issue(make_item(OP_ADD, 16'sh7fff, 16'sh7fff, 7'd100, '0, '0), 0);
		issue(make_item(OP_ADD, 16'sh8000, 16'sh8000, 7'd0, '0, '0), 0);
		issue(make_item(OP_ADD, 16'sd0, 16'sd0, 7'd127, '0, '0), 0);
		issue(make_item(OP_ADD, -16'sd1, 16'sd0, 7'd1, '0, '0), 0);
		issue(make_item(OP_ADD, 16'sd12345, 16'sh7fff, 7'd42, '0, '0), 0);
		issue(make_item(OP_ADD, 16'sh5555, 16'sh8000, 7'd85, '0, '0), 0);
		issue(make_item(OP_UNUSED, 16'shffff, 16'shffff, 7'd127, 16'shffff, 16'shffff), 0);
		issue(make_item(OP_RENDER, '0, '0, '0, 16'sd0, 16'sd0), 0);
		issue(make_item(OP_RENDER, '0, '0, '0, 16'sh7fff, 16'sh7fff), 0);
		issue(make_item(OP_RENDER, '0, '0, '0, 16'sh8000, 16'sh8000), 0);
		issue(make_item(OP_RENDER, 16'shffff, 16'shffff, 7'd127, -16'sd1, 16'sd1), 0);
		issue(make_item(OP_CLEAR, '0, '0, '0, '0, '0), 0);
		issue(make_item(OP_RENDER, '0, '0, '0, 16'sd3, 16'sd3), 0);
		issue(make_item(OP_CLEAR, '0, '0, '0, '0, '0), 0);
		issue(make_item(OP_ADD, 16'sh2aaa, -16'sd7, 7'd50, '0, '0), 0);
		issue(make_item(OP_RENDER, '0, '0, '0, 16'sh1234, -16'sd9), 0);
		issue(make_item(OP_CLEAR, '0, '0, '0, '0, '0), 0);
		drain();

		// Random part: sender idling at two rates, then back to back.
		run_phase(36, 15, 1'b0);
		drain();
		run_phase(47, 45, 1'b1);
		run_phase(0, 15, 1'b0);

		// Wait for the last results, then a margin for anything stray.
		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legitimate run.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- depth_sorted_draw_list.f -----
+incdir+hdl
hdl/dsdl_pkg.sv
hdl/dsdl_cell.sv
hdl/dsdl_chain.sv
hdl/depth_sorted_draw_list.sv
verif/depth_sorted_draw_list_checker.sv
verif/depth_sorted_draw_list_tb.sv
